### sv/band_centroid_extractor_core_defines.svh
// ----------------------------------------------------------------------------
// Band centroid extractor assertion macros
// Shared assertion wrappers; they compile away when SYNTHESIS is defined.
// Both expect signals named clk and rst in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef BAND_CENTROID_EXTRACTOR_CORE_DEFINES_SVH
`define BAND_CENTROID_EXTRACTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define BCX_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bcx: assertion failed");
// Check that a condition implies another in the same cycle
`define BCX_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("bcx: implication failed");
`else
`define BCX_ASSERT(label, prop)
`define BCX_ASSERT_IMPL(label, pre, post)
`endif

`endif

### sv/bcx_pkg.sv
// ----------------------------------------------------------------------------
// Band centroid extractor package
// Shared widths, register codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bcx_pkg;

  // Default size limits
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned DEF_MAX_BANDS  = 64;
  localparam int unsigned DEF_FRAC_BITS  = 8;

  // Register reset values
  localparam int unsigned RST_IMAGE_WIDTH  = 640;
  localparam int unsigned RST_IMAGE_HEIGHT = 480;
  localparam int unsigned RST_BAND_COUNT   = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned BAND_COUNT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT   = 2'd2;

  // Result fields
  localparam int unsigned BAND_INDEX_W = 6;
  localparam int unsigned Q_W          = 20;
  localparam logic [Q_W-1:0] Q_MAX     = '1;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = BAND_INDEX_W + 2 * Q_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_BH_START,
    ST_BH_WAIT,
    ST_RUN,
    ST_X_START,
    ST_X_WAIT,
    ST_Y_START,
    ST_Y_WAIT,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_BH,
    DIV_X,
    DIV_Y
  } div_sel_t;

  typedef struct packed {
    logic     pix_take;
    logic     cfg_take;
    logic     div_start;
    div_sel_t div_sel;
    logic     bh_load;
    logic     x_load;
    logic     y_load;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic band_end;
    logic acc_empty;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### sv/band_centroid_extractor_core.sv
// ----------------------------------------------------------------------------
// Band centroid extractor
// Per band centroid of a binary mask image streamed in raster order.
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock while a band is being scanned and no
// configuration write is pending. On the last pixel of each band the block
// stops taking pixels while the shared serial divider works out x and y,
// one quotient bit per cycle, for QW = clog2(max(MAX_WIDTH, MAX_HEIGHT) + 1)
// + FRAC_BITS quotient bits (21 by default); an empty band skips the
// divisions. A band result also waits for the result register to drain.
// Each configuration write recomputes the band height with the same divider
// and holds off pixels until that division is done; after reset the first
// pixel is taken once the band height has been computed.
// The result register lets the next band be scanned while a result waits.
// ----------------------------------------------------------------------------
module band_centroid_extractor_core #(
  parameter int unsigned MAX_WIDTH  = bcx_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bcx_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_BANDS  = bcx_pkg::DEF_MAX_BANDS,
  parameter int unsigned FRAC_BITS  = bcx_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Pixel request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bcx_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] pixel_on
  input  logic                            s_axis_tuser,  // [0] frame_start
  // Band result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [5:0] band_index, [25:6] centroid_x_q8, [45:26] centroid_y_q8
  output logic [bcx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,  // [0] found
  output logic                            m_axis_tlast,  // last_band
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bcx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcx_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bcx_pkg::ctrl_cmd_t  cmd;
  bcx_pkg::dp_status_t st;

  bcx_controller u_controller (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .st            (st),
    .cmd           (cmd)
  );

  bcx_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BANDS  (MAX_BANDS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .pixel_on      (s_axis_tdata[0]),
    .frame_start   (s_axis_tuser),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### sv/bcx_divider.sv
// ----------------------------------------------------------------------------
// Band centroid extractor divider
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits (num < den << QUO_W).
// ----------------------------------------------------------------------------
module bcx_divider #(
  parameter int unsigned NUM_W = 45,
  parameter int unsigned DEN_W = 25,
  parameter int unsigned QUO_W = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int unsigned STEP_W = $clog2(QUO_W + 1);

  logic [STEP_W-1:0] steps_left;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic [QUO_W-1:0]  shreg;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // Trial subtract of the next numerator bit
  assign trial = {rem, shreg[QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});
  assign quo   = shreg;

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        steps_left <= STEP_W'(QUO_W);
      end else if (busy) begin
        steps_left <= steps_left - STEP_W'(1);
        if (steps_left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift numerator bits in, quotient bits out
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DEN_W'(num >> QUO_W);
      shreg <= num[QUO_W-1:0];
      den_q <= den;
    end else if (busy) begin
      rem   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      shreg <= {shreg[QUO_W-2:0], fits};
    end
  end

endmodule

### sv/bcx_datapath.sv
// ----------------------------------------------------------------------------
// Band centroid extractor datapath
// Configuration registers, raster position counters, band accumulators,
// the shared divider, the band start multiplier and the result register.
// ----------------------------------------------------------------------------
`include "band_centroid_extractor_core_defines.svh"

module bcx_datapath #(
  parameter int unsigned MAX_WIDTH  = bcx_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bcx_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_BANDS  = bcx_pkg::DEF_MAX_BANDS,
  parameter int unsigned FRAC_BITS  = bcx_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bcx_pkg::ctrl_cmd_t                 cmd,
  output bcx_pkg::dp_status_t                st,
  input  logic                               pixel_on,
  input  logic                               frame_start,
  input  logic [bcx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcx_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bcx_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT);
  localparam int unsigned W_W       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W       = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NB_W      = $clog2(MAX_BANDS + 1);
  localparam int unsigned MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned PIX_CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned SX_W      = PIX_CNT_W + COL_W;
  localparam int unsigned SY_W      = PIX_CNT_W + ROW_W;
  localparam int unsigned SUM_W     = (SX_W > SY_W) ? SX_W : SY_W;
  localparam int unsigned NUM_W     = SUM_W + FRAC_BITS;
  localparam int unsigned QUO_W     = $clog2(MAX_DIM + 1) + FRAC_BITS;
  localparam int unsigned ST_W      = NB_W + H_W;
  localparam int unsigned YA_W      =
      (QUO_W > H_W + FRAC_BITS) ? QUO_W : H_W + FRAC_BITS;
  localparam int unsigned RES_W     = ((YA_W > bcx_pkg::Q_W) ? YA_W : bcx_pkg::Q_W) + 1;
  localparam int unsigned PAD_W     = bcx_pkg::OUT_TDATA_W - bcx_pkg::OUT_FIELD_W;

  localparam int unsigned W_RST  =
      (bcx_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : bcx_pkg::RST_IMAGE_WIDTH;
  localparam int unsigned H_RST  =
      (bcx_pkg::RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : bcx_pkg::RST_IMAGE_HEIGHT;
  localparam int unsigned NB_RST =
      (bcx_pkg::RST_BAND_COUNT > MAX_BANDS) ? MAX_BANDS : bcx_pkg::RST_BAND_COUNT;

  // Zero reads as one, oversize saturates at the limit
  function automatic logic [bcx_pkg::CFG_DATA_W:0] clamp_reg(
    input logic [bcx_pkg::CFG_DATA_W-1:0] v,
    input int unsigned                    hi
  );
    logic [bcx_pkg::CFG_DATA_W:0] ve;
    ve = {1'b0, v};
    if (v == '0) begin
      return (bcx_pkg::CFG_DATA_W + 1)'(1);
    end else if (ve > (bcx_pkg::CFG_DATA_W + 1)'(hi)) begin
      return (bcx_pkg::CFG_DATA_W + 1)'(hi);
    end else begin
      return ve;
    end
  endfunction

  function automatic logic [bcx_pkg::Q_W-1:0] sat_q(input logic [RES_W-1:0] v);
    if (v > RES_W'(bcx_pkg::Q_MAX)) begin
      return bcx_pkg::Q_MAX;
    end else begin
      return bcx_pkg::Q_W'(v);
    end
  endfunction

  // Effective configuration
  logic [W_W-1:0]  img_w;
  logic [H_W-1:0]  img_h;
  logic [NB_W-1:0] band_num;
  logic [H_W-1:0]  band_height;

  // Scan state
  logic [COL_W-1:0]     column_pos;
  logic [ROW_W-1:0]     row_in_band;
  logic [NB_W-1:0]      current_band;
  logic [PIX_CNT_W-1:0] set_pixel_count;
  logic [SX_W-1:0]      sum_of_columns;
  logic [SY_W-1:0]      sum_of_row_offsets;

  // Position after an optional frame restart
  logic [COL_W-1:0]     col_b;
  logic [ROW_W-1:0]     row_b;
  logic [NB_W-1:0]      band_b;
  logic [PIX_CNT_W-1:0] cnt_b;
  logic [SX_W-1:0]      sx_b;
  logic [SY_W-1:0]      sy_b;
  logic                 active;
  logic                 col_end;
  logic                 row_end;

  logic [COL_W-1:0]     column_pos_next;
  logic [ROW_W-1:0]     row_in_band_next;
  logic [PIX_CNT_W-1:0] set_pixel_count_next;
  logic [SX_W-1:0]      sum_of_columns_next;
  logic [SY_W-1:0]      sum_of_row_offsets_next;

  // Division and result
  logic [NUM_W-1:0]     div_num;
  logic [PIX_CNT_W-1:0] div_den;
  logic [QUO_W-1:0]     div_quo;
  logic                 div_busy;
  logic                 div_done;
  logic [ST_W-1:0]      band_start;
  logic [bcx_pkg::Q_W-1:0] x_q;
  logic [bcx_pkg::Q_W-1:0] y_q;

  localparam int unsigned BAND_INDEX_LOCAL_W = bcx_pkg::BAND_INDEX_W;
  logic [BAND_INDEX_LOCAL_W-1:0] out_band;
  logic [bcx_pkg::Q_W-1:0] out_x;
  logic [bcx_pkg::Q_W-1:0] out_y;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w    <= W_W'(W_RST);
      img_h    <= H_W'(H_RST);
      band_num <= NB_W'(NB_RST);
    end else if (cmd.cfg_take) begin
      unique case (cfg_index)
        bcx_pkg::REG_IMAGE_WIDTH:  img_w <= W_W'(clamp_reg(cfg_data, MAX_WIDTH));
        bcx_pkg::REG_IMAGE_HEIGHT: img_h <= H_W'(clamp_reg(cfg_data, MAX_HEIGHT));
        bcx_pkg::REG_BAND_COUNT: begin
          band_num <= NB_W'(clamp_reg(
              bcx_pkg::CFG_DATA_W'(cfg_data[bcx_pkg::BAND_COUNT_W-1:0]), MAX_BANDS));
        end
        default: ;
      endcase
    end
  end

  // Hold band height from the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      band_height <= '0;
    end else if (cmd.bh_load) begin
      band_height <= H_W'(div_quo);
    end
  end

  // Advance raster position for the offered pixel
  always_comb begin
    col_b  = frame_start ? '0 : column_pos;
    row_b  = frame_start ? '0 : row_in_band;
    band_b = frame_start ? '0 : current_band;
    cnt_b  = frame_start ? '0 : set_pixel_count;
    sx_b   = frame_start ? '0 : sum_of_columns;
    sy_b   = frame_start ? '0 : sum_of_row_offsets;

    active  = (band_height != '0) && (band_b < band_num);
    col_end = (W_W'(col_b) >= (img_w - W_W'(1)));
    row_end = (H_W'(row_b) >= (band_height - H_W'(1)));

    column_pos_next         = col_b;
    row_in_band_next        = row_b;
    set_pixel_count_next    = cnt_b;
    sum_of_columns_next     = sx_b;
    sum_of_row_offsets_next = sy_b;
    if (active) begin
      if (pixel_on) begin
        set_pixel_count_next    = cnt_b + PIX_CNT_W'(1);
        sum_of_columns_next     = sx_b + SX_W'(col_b);
        sum_of_row_offsets_next = sy_b + SY_W'(row_b);
      end
      if (col_end) begin
        column_pos_next  = '0;
        row_in_band_next = row_end ? '0 : row_b + ROW_W'(1);
      end else begin
        column_pos_next = col_b + COL_W'(1);
      end
    end
  end

  // Update scan state on a taken pixel, close the band on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos         <= '0;
      row_in_band        <= '0;
      current_band       <= '0;
      set_pixel_count    <= '0;
      sum_of_columns     <= '0;
      sum_of_row_offsets <= '0;
    end else if (cmd.pix_take) begin
      column_pos         <= column_pos_next;
      row_in_band        <= row_in_band_next;
      current_band       <= band_b;
      set_pixel_count    <= set_pixel_count_next;
      sum_of_columns     <= sum_of_columns_next;
      sum_of_row_offsets <= sum_of_row_offsets_next;
    end else if (cmd.emit) begin
      current_band       <= current_band + NB_W'(1);
      set_pixel_count    <= '0;
      sum_of_columns     <= '0;
      sum_of_row_offsets <= '0;
    end
  end

  // Band start row for the y offset
  always_ff @(posedge clk) begin
    band_start <= ST_W'(current_band) * ST_W'(band_height);
  end

  // Select divider operands
  always_comb begin
    unique case (cmd.div_sel)
      bcx_pkg::DIV_BH: begin
        div_num = NUM_W'(img_h);
        div_den = PIX_CNT_W'(band_num);
      end
      bcx_pkg::DIV_X: begin
        div_num = NUM_W'(sum_of_columns) << FRAC_BITS;
        div_den = set_pixel_count;
      end
      bcx_pkg::DIV_Y: begin
        div_num = NUM_W'(sum_of_row_offsets) << FRAC_BITS;
        div_den = set_pixel_count;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  bcx_divider #(
    .NUM_W (NUM_W),
    .DEN_W (PIX_CNT_W),
    .QUO_W (QUO_W)
  ) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Capture centroid coordinates
  always_ff @(posedge clk) begin
    if (cmd.x_load) begin
      x_q <= sat_q(RES_W'(div_quo));
    end
    if (cmd.y_load) begin
      y_q <= sat_q((RES_W'(band_start) << FRAC_BITS) + RES_W'(div_quo));
    end
  end

  // Result register toward the output stream
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_band     <= BAND_INDEX_LOCAL_W'(current_band);
      m_axis_tuser <= (set_pixel_count != '0);
      out_x        <= (set_pixel_count != '0) ? x_q : '0;
      out_y        <= (set_pixel_count != '0) ? y_q : '0;
      m_axis_tlast <= (current_band == (band_num - NB_W'(1)));
    end
  end

  assign m_axis_tdata = {PAD_W'(0), out_y, out_x, out_band};

  // Status toward the controller
  assign st.band_end  = active && col_end && row_end;
  assign st.acc_empty = (set_pixel_count == '0);
  assign st.div_busy  = div_busy;
  assign st.div_done  = div_done;
  assign st.out_free  = !m_axis_tvalid || m_axis_tready;

  `BCX_ASSERT(a_emit_clears_acc, cmd.emit |=> (set_pixel_count == '0))
  `BCX_ASSERT_IMPL(a_no_overwrite, m_axis_tvalid && !m_axis_tready, !cmd.emit)
  `BCX_ASSERT_IMPL(a_emit_band_in_range, cmd.emit, current_band < band_num)

endmodule

### sv/bcx_controller.sv
// ----------------------------------------------------------------------------
// Band centroid extractor controller
// Sequences band height setup, pixel intake and the per band divisions,
// and hands results to the output register.
// ----------------------------------------------------------------------------
`include "band_centroid_extractor_core_defines.svh"

module bcx_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bcx_pkg::dp_status_t st,
  output bcx_pkg::ctrl_cmd_t  cmd
);

  bcx_pkg::ctrl_state_t state;
  bcx_pkg::ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcx_pkg::ST_BH_START;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bcx_pkg::ST_BH_START: state_next = bcx_pkg::ST_BH_WAIT;
      bcx_pkg::ST_BH_WAIT: begin
        if (st.div_done) state_next = bcx_pkg::ST_RUN;
      end
      bcx_pkg::ST_RUN: begin
        if (cfg_valid) begin
          state_next = bcx_pkg::ST_BH_START;
        end else if (s_axis_tvalid && st.band_end) begin
          state_next = bcx_pkg::ST_X_START;
        end
      end
      bcx_pkg::ST_X_START: begin
        state_next = st.acc_empty ? bcx_pkg::ST_EMIT : bcx_pkg::ST_X_WAIT;
      end
      bcx_pkg::ST_X_WAIT: begin
        if (st.div_done) state_next = bcx_pkg::ST_Y_START;
      end
      bcx_pkg::ST_Y_START: state_next = bcx_pkg::ST_Y_WAIT;
      bcx_pkg::ST_Y_WAIT: begin
        if (st.div_done) state_next = bcx_pkg::ST_EMIT;
      end
      bcx_pkg::ST_EMIT: begin
        if (st.out_free) state_next = bcx_pkg::ST_RUN;
      end
      default: state_next = bcx_pkg::ST_BH_START;
    endcase
  end

  // Commands and handshakes
  always_comb begin
    cmd           = '0;
    cmd.div_sel   = bcx_pkg::DIV_X;
    s_axis_tready = 1'b0;
    cfg_ready     = 1'b0;
    unique case (state)
      bcx_pkg::ST_BH_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bcx_pkg::DIV_BH;
      end
      bcx_pkg::ST_BH_WAIT: cmd.bh_load = st.div_done;
      bcx_pkg::ST_RUN: begin
        cfg_ready     = 1'b1;
        s_axis_tready = !cfg_valid;
        cmd.cfg_take  = cfg_valid;
        cmd.pix_take  = s_axis_tvalid && !cfg_valid;
      end
      bcx_pkg::ST_X_START: cmd.div_start = !st.acc_empty;
      bcx_pkg::ST_X_WAIT:  cmd.x_load    = st.div_done;
      bcx_pkg::ST_Y_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = bcx_pkg::DIV_Y;
      end
      bcx_pkg::ST_Y_WAIT: cmd.y_load = st.div_done;
      bcx_pkg::ST_EMIT:   cmd.emit   = st.out_free;
      default: ;
    endcase
  end

  `BCX_ASSERT_IMPL(a_div_start_idle, cmd.div_start, !st.div_busy)
  `BCX_ASSERT(a_band_end_divides, (cmd.pix_take && st.band_end) |=> (state == bcx_pkg::ST_X_START))
  `BCX_ASSERT(a_cfg_recomputes, cmd.cfg_take |=> (state == bcx_pkg::ST_BH_START))

endmodule
